/* rtl/skde_pkg.sv */
// ----------------------------------------------------------------------------
// skde_pkg
// Shared types and constants of the scanned key debounce block.
// ----------------------------------------------------------------------------
`default_nettype none

package skde_pkg;

  // Default number of key pins in one scan
  localparam int PIN_COUNT_DEF = 28;

  // Field widths
  localparam int TIME_W     = 32;
  localparam int DEBOUNCE_W = 20;
  localparam int NOTE_W     = 7;
  localparam int CHANNEL_W  = 5;

  // Configuration register indexes and bus geometry
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_NOTE     = 2'd1;
  localparam logic [1:0] REG_CHANNEL  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(30000);
  localparam logic [NOTE_W-1:0]     NOTE_RST     = '0;
  localparam logic [CHANNEL_W-1:0]  CHANNEL_RST  = CHANNEL_W'(1);

  // Debounce state of one pin
  typedef struct packed {
    logic              stable;
    logic              settling;
    logic [TIME_W-1:0] start;
  } pin_state_t;

  // One event handed to the emitter
  typedef struct packed {
    logic              valid;
    logic [NOTE_W-1:0] note;
    logic              pressed;
  } key_event_t;

  // Emitter status back to the sequencer
  typedef struct packed {
    logic take_ok;
    logic flush_done;
  } emit_status_t;

endpackage

`default_nettype wire

/* rtl/skde_cell.sv */
// ----------------------------------------------------------------------------
// skde_cell
// One cell of the pin state ring: holds the debounce state of one pin and
// takes its neighbour's state whenever the ring advances.
// ----------------------------------------------------------------------------
`default_nettype none

module skde_cell
  import skde_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       shift,
  input  wire pin_state_t state_in,
  output pin_state_t      state_out
);

  logic              stable;
  logic              settling;
  logic [TIME_W-1:0] start;

  // Advance control bits, clear them on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      stable   <= 1'b0;
      settling <= 1'b0;
    end else if (shift) begin
      stable   <= state_in.stable;
      settling <= state_in.settling;
    end
  end

  // Advance the start time; only read while settling
  always_ff @(posedge clk) begin
    if (shift) begin
      start <= state_in.start;
    end
  end

  assign state_out = '{stable, settling, start};

endmodule

`default_nettype wire

/* rtl/skde_emit.sv */
// ----------------------------------------------------------------------------
// skde_emit
// Event emitter: holds the newest event back by one so that the final event
// of a scan can be marked, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module skde_emit
  import skde_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire key_event_t           ev,
  input  wire logic                 flush,
  input  wire logic [CHANNEL_W-1:0] channel_cfg,
  output emit_status_t              status,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [NOTE_W-1:0]         note,
  output logic                      pressed,
  output logic [CHANNEL_W-1:0]      channel,
  output logic                      last_event
);

  logic              pend_valid;
  logic [NOTE_W-1:0] pend_note;
  logic              pend_pressed;
  logic              out_free;
  logic              push;

  assign out_free = !out_valid || out_ready;

  // Push the held event when a newer one arrives or the scan ends
  assign push = pend_valid && (ev.valid || (flush && out_free));

  assign status.take_ok    = !pend_valid || out_free;
  assign status.flush_done = !pend_valid || out_free;

  // Track held and output valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (ev.valid) begin
        pend_valid <= 1'b1;
      end else if (push) begin
        pend_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the newest event and load the output register
  always_ff @(posedge clk) begin
    if (ev.valid) begin
      pend_note    <= ev.note;
      pend_pressed <= ev.pressed;
    end
    if (push) begin
      note       <= pend_note;
      pressed    <= pend_pressed;
      channel    <= channel_cfg;
      last_event <= !ev.valid;
    end
  end

  // A new event must only come when the held one can move on
  assert property (@(posedge clk) disable iff (rst) ev.valid |-> status.take_ok)
    else $error("event offered while the emitter is blocked");

  // A flushed scan ends with its final event in the output register
  assert property (@(posedge clk) disable iff (rst)
                   (flush && !ev.valid && pend_valid && out_free) |=> (out_valid && last_event))
    else $error("final event of a scan not marked");

endmodule

`default_nettype wire

/* rtl/scanned_key_debounce_events.sv */
// ----------------------------------------------------------------------------
// scanned_key_debounce_events
// Debounces one scan of active-low key pins and emits note on/off events.
// ----------------------------------------------------------------------------
// Each accepted scan walks the per-pin debounce state once around a ring of
// PIN_COUNT cells, one pin per cycle, through a single update unit at the head
// of the ring; a scan runs from acceptance through PIN_COUNT ring steps and a
// flush state back to idle, where the next scan is accepted, and a ring step
// waits while the output side stalls with two events pending.
// Events leave in ascending pin order and the final one of a scan carries
// last_event; a scan that accepts no change produces no item. The next scan
// may be accepted while the last event of the previous one still waits in
// the output register. Registers sit at byte addresses 0 (debounce time),
// 4 (note base) and 8 (channel).
// ----------------------------------------------------------------------------
`default_nettype none

module scanned_key_debounce_events
  import skde_pkg::*;
#(
  parameter int PIN_COUNT = PIN_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready,
  // Scan input
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [PIN_COUNT-1:0]  raw_pins,
  input  wire logic [TIME_W-1:0]     now_us,
  // Event output
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [NOTE_W-1:0]          note,
  output logic                       pressed,
  output logic [CHANNEL_W-1:0]       channel,
  output logic                       last_event
);

  localparam int IDX_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PIN_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH
  } seq_state_t;

  seq_state_t state;

  logic [DEBOUNCE_W-1:0] debounce_time_us;
  logic [NOTE_W-1:0]     note_base;
  logic [CHANNEL_W-1:0]  channel_number;

  logic [PIN_COUNT-1:0]  pins;
  logic [TIME_W-1:0]     now;
  logic [IDX_W-1:0]      idx;

  pin_state_t            ring [PIN_COUNT];
  pin_state_t            head_next;
  logic                  level;
  logic [TIME_W-1:0]     elapsed;
  logic                  hit;
  logic                  step;
  key_event_t            ev;
  emit_status_t          emit_status;
  logic                  cfg_write;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time_us <= DEBOUNCE_RST;
      note_base        <= NOTE_RST;
      channel_number   <= CHANNEL_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_DEBOUNCE: debounce_time_us <= pwdata[DEBOUNCE_W-1:0];
        REG_NOTE:     note_base        <= pwdata[NOTE_W-1:0];
        REG_CHANNEL:  channel_number   <= pwdata[CHANNEL_W-1:0];
        default:      ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (paddr[3:2])
      REG_DEBOUNCE: prdata = CFG_DATA_W'(debounce_time_us);
      REG_NOTE:     prdata = CFG_DATA_W'(note_base);
      REG_CHANNEL:  prdata = CFG_DATA_W'(channel_number);
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Update unit at the head of the ring
  // --------------------------------------------------------------------------
  assign level   = !pins[0];
  assign elapsed = now - ring[0].start;

  always_comb begin
    head_next = ring[0];
    hit       = 1'b0;
    priority if (level == ring[0].stable) begin
      head_next.settling = 1'b0;
    end else if (!ring[0].settling) begin
      head_next.settling = 1'b1;
      head_next.start    = now;
    end else if (elapsed > TIME_W'(debounce_time_us)) begin
      head_next.stable   = level;
      head_next.settling = 1'b0;
      hit                = 1'b1;
    end else begin
      // Keep timing the change
      head_next.settling = 1'b1;
    end
  end

  // Advance only when the emitter can take a possible event
  assign step       = (state == S_RUN) && (!hit || emit_status.take_ok);
  assign ev.valid   = step && hit;
  assign ev.note    = note_base + NOTE_W'(idx);
  assign ev.pressed = level;

  // --------------------------------------------------------------------------
  // Ring of pin cells: each takes its neighbour, the tail takes the update
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < PIN_COUNT; i++) begin : g_cell
    pin_state_t cell_in;
    if (i == PIN_COUNT - 1) begin : g_tail
      assign cell_in = head_next;
    end else begin : g_body
      assign cell_in = ring[i+1];
    end
    skde_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (step),
      .state_in  (cell_in),
      .state_out (ring[i])
    );
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RUN;
            idx   <= '0;
          end
        end
        S_RUN: begin
          if (step) begin
            if (idx == IDX_LAST) begin
              state <= S_FLUSH;
              idx   <= '0;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        S_FLUSH: begin
          if (emit_status.flush_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Load the scan, then shift one pin out per ring step
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pins <= raw_pins;
      now  <= now_us;
    end else if (step) begin
      pins <= pins >> 1;
    end
  end

  // --------------------------------------------------------------------------
  // Event emitter
  // --------------------------------------------------------------------------
  skde_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .ev          (ev),
    .flush       (state == S_FLUSH),
    .channel_cfg (channel_number),
    .status      (emit_status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .note        (note),
    .pressed     (pressed),
    .channel     (channel),
    .last_event  (last_event)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> (idx == '0))
    else $error("pin index not at zero while idle");

  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> (state == S_RUN))
    else $error("accepted scan did not start the ring walk");

  assert property (@(posedge clk) disable iff (rst)
                   (step && idx == IDX_LAST) |=> (state == S_FLUSH))
    else $error("ring walk did not end after the last pin");

endmodule

`default_nettype wire
